// ===== rtl/assert_macros.svh =====
// assertion macros for the rtl core that checks itself
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication on the rising clock edge, off during reset
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication on the rising clock edge, off during reset
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== rtl/cma_pkg.sv =====
// shared types and constants for the cluster mode assignment block
package cma_pkg;

	localparam int MAX_MODES  = 64;
	localparam int DIMENSIONS = 3;
	localparam int COORD_BITS = 16;
	localparam int RAD_W      = 34;

	localparam int LANES  = 4;
	localparam int LANE_W = $clog2(LANES);
	localparam int ROWS   = (MAX_MODES + LANES - 1) / LANES;
	localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int IDX_W  = 6;
	localparam int CNT_W  = $clog2(MAX_MODES + 1);

	localparam int SQ_W  = 2 * COORD_BITS;
	localparam int SUM_W = SQ_W + $clog2(DIMENSIONS);
	localparam int CMP_W = (SUM_W > RAD_W) ? SUM_W : RAD_W;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [DIMENSIONS-1:0][COORD_BITS-1:0] point_t;

	typedef struct packed {
		logic   start_new;
		coord_t coord_x;
		coord_t coord_y;
		coord_t coord_z;
	} in_word_t;

	typedef struct packed {
		coord_t           mode_x;
		coord_t           mode_y;
		coord_t           mode_z;
		logic [IDX_W-1:0] cluster_index;
		logic             created;
		logic             table_full;
		logic [CNT_W-1:0] clusters_now;
	} out_word_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic             en;
	} issue_t;

	typedef struct packed {
		logic             we;
		logic [ROW_W-1:0] row;
		point_t           data;
	} wr_t;

endpackage

// ===== rtl/cluster_mode_assign_core.sv =====
// top level: cluster mode assignment over four table lanes with a merge stage
// a point scans rows of four modes, one row issued per cycle, three stages deep
// strobe is registered from a stage-three hit or once all rows drain, rows = ceil(count/4)
// busy stays high until the strobe cycle; the next start is taken in that cycle
// reset clears the count, the radius and the control; table contents stay undefined
// results cannot be stalled and appear for exactly one cycle
`include "assert_macros.svh"

module cluster_mode_assign_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  cma_pkg::in_word_t           item,
	output logic                        strobe,
	output cma_pkg::out_word_t          result,
	input  logic                        cfg_we,
	input  logic [cma_pkg::RAD_W-1:0]   cfg_wdata
);

	typedef enum logic {
		IDLE,
		SCAN
	} state_t;

	state_t                     state_q;
	logic [cma_pkg::RAD_W-1:0]  radius_q;
	cma_pkg::point_t            point_q;
	logic [cma_pkg::CNT_W-1:0]  count_q, nrows_q, issue_q;
	logic                       v_s1, v_s2, v_s3;
	logic [cma_pkg::ROW_W-1:0]  row_s1, row_s2, row_s3;
	logic                       strobe_q;
	cma_pkg::out_word_t         result_q;

	cma_pkg::issue_t            issue [cma_pkg::LANES];
	cma_pkg::wr_t               wr [cma_pkg::LANES];
	logic [cma_pkg::LANES-1:0]  hit;
	cma_pkg::point_t            lane_data [cma_pkg::LANES];
	logic                       any_hit;
	logic [cma_pkg::LANE_W-1:0] hit_lane;
	cma_pkg::point_t            hit_mode;

	logic                       matched, issuing, drained, insert;
	logic [cma_pkg::CNT_W-1:0]  cnt_start;
	logic [cma_pkg::CNT_W:0]    rows_sum;
	cma_pkg::point_t            item_point;

	assign item_point = {item.coord_z, item.coord_y, item.coord_x};
	assign cnt_start  = item.start_new ? '0 : count_q;
	assign rows_sum   = {1'b0, cnt_start} + (cma_pkg::CNT_W + 1)'(cma_pkg::LANES - 1);
	assign matched    = v_s3 && any_hit;
	assign issuing    = (state_q == SCAN) && (issue_q < nrows_q) && !matched;
	assign drained    = !issuing && !v_s1 && !v_s2 && !v_s3;
	assign insert     = (state_q == SCAN) && drained
		&& (count_q < cma_pkg::CNT_W'(cma_pkg::MAX_MODES));

	for (genvar l = 0; l < cma_pkg::LANES; l++) begin : g_lane
		logic [cma_pkg::ROW_W+cma_pkg::LANE_W-1:0] entry;
		assign entry = {issue_q[cma_pkg::ROW_W-1:0], cma_pkg::LANE_W'(l)};
		assign issue[l].row = issue_q[cma_pkg::ROW_W-1:0];
		assign issue[l].en  = issuing && (cma_pkg::CNT_W'(entry) < count_q);
		assign wr[l].we   = insert && (count_q[cma_pkg::LANE_W-1:0] == cma_pkg::LANE_W'(l));
		assign wr[l].row  = count_q[cma_pkg::ROW_W+cma_pkg::LANE_W-1:cma_pkg::LANE_W];
		assign wr[l].data = point_q;

		cma_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.issue  (issue[l]),
			.wr     (wr[l]),
			.point  (point_q),
			.radius (radius_q),
			.hit    (hit[l]),
			.data   (lane_data[l])
		);
	end

	cma_merge u_merge (
		.hit  (hit),
		.data (lane_data),
		.any  (any_hit),
		.lane (hit_lane),
		.mode (hit_mode)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= '0;
		end else if (cfg_we) begin
			radius_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		row_s1 <= issue_q[cma_pkg::ROW_W-1:0];
		row_s2 <= row_s1;
		row_s3 <= row_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= IDLE;
			count_q  <= '0;
			nrows_q  <= '0;
			issue_q  <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			strobe_q <= 1'b0;
			point_q  <= '0;
			result_q <= '0;
		end else begin
			v_s1     <= issuing;
			v_s2     <= v_s1 && !matched;
			v_s3     <= v_s2 && !matched;
			unique case (state_q)
				IDLE: begin
					strobe_q <= 1'b0;
					if (start) begin
						point_q <= item_point;
						count_q <= cnt_start;
						nrows_q <= cma_pkg::CNT_W'(rows_sum >> cma_pkg::LANE_W);
						issue_q <= '0;
						state_q <= SCAN;
					end
				end
				SCAN: begin
					if (issuing) begin
						issue_q <= issue_q + 1'b1;
					end
					if (matched) begin
						strobe_q <= 1'b1;
						result_q.mode_x        <= hit_mode[0];
						result_q.mode_y        <= hit_mode[1];
						result_q.mode_z        <= hit_mode[2];
						result_q.cluster_index <= cma_pkg::IDX_W'({row_s3, hit_lane});
						result_q.created       <= 1'b0;
						result_q.table_full    <= 1'b0;
						result_q.clusters_now  <= count_q;
						state_q <= IDLE;
					end else if (drained) begin
						strobe_q <= 1'b1;
						result_q.mode_x <= point_q[0];
						result_q.mode_y <= point_q[1];
						result_q.mode_z <= point_q[2];
						if (insert) begin
							result_q.cluster_index <= count_q[cma_pkg::IDX_W-1:0];
							result_q.created       <= 1'b1;
							result_q.table_full    <= 1'b0;
							result_q.clusters_now  <= count_q + 1'b1;
							count_q <= count_q + 1'b1;
						end else begin
							result_q.cluster_index <= '0;
							result_q.created       <= 1'b0;
							result_q.table_full    <= 1'b1;
							result_q.clusters_now  <= count_q;
						end
						state_q <= IDLE;
					end else begin
						strobe_q <= 1'b0;
					end
				end
				default: begin
					strobe_q <= 1'b0;
					state_q  <= IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != IDLE);
	assign strobe = strobe_q;
	assign result = result_q;

	`ASSERT_SAME(a_strobe_idle, strobe, !busy)
	`ASSERT_NEXT(a_start_busy, start && !busy, busy)
	`ASSERT_SAME(a_created_ok, strobe && result.created,
		!result.table_full && (result.clusters_now != '0))
	`ASSERT_SAME(a_full_count, strobe && result.table_full,
		result.clusters_now == cma_pkg::CNT_W'(cma_pkg::MAX_MODES))
	`ASSERT_SAME(a_issue_scan, v_s3, state_q == SCAN)

endmodule

// ===== rtl/cma_lane.sv =====
// one lane: a slice of the mode table and a squared-distance test pipeline
module cma_lane (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cma_pkg::issue_t       issue,
	input  cma_pkg::wr_t          wr,
	input  cma_pkg::point_t       point,
	input  logic [cma_pkg::RAD_W-1:0] radius,
	output logic                  hit,
	output cma_pkg::point_t       data
);

	cma_pkg::point_t mem [cma_pkg::ROWS];

	cma_pkg::point_t data_s1, data_s2, data_s3;
	logic            en_s1, en_s2, hit_s3;
	logic [cma_pkg::DIMENSIONS-1:0][cma_pkg::SQ_W-1:0] sq_d, sq_s2;
	logic [cma_pkg::SUM_W-1:0] sum_d;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.row] <= wr.data;
		end
		data_s1 <= mem[issue.row];
		data_s2 <= data_s1;
		data_s3 <= data_s2;
		sq_s2   <= sq_d;
	end

	always_comb begin
		logic signed [cma_pkg::COORD_BITS:0] diff;
		logic [cma_pkg::COORD_BITS:0]        neg;
		logic [cma_pkg::COORD_BITS-1:0]      mag;
		for (int d = 0; d < cma_pkg::DIMENSIONS; d++) begin
			diff = $signed({point[d][cma_pkg::COORD_BITS-1], point[d]})
				- $signed({data_s1[d][cma_pkg::COORD_BITS-1], data_s1[d]});
			neg = diff[cma_pkg::COORD_BITS] ? (~diff + 1'b1) : diff;
			mag = neg[cma_pkg::COORD_BITS-1:0];
			sq_d[d] = cma_pkg::SQ_W'(mag) * cma_pkg::SQ_W'(mag);
		end
	end

	always_comb begin
		sum_d = '0;
		for (int d = 0; d < cma_pkg::DIMENSIONS; d++) begin
			sum_d = sum_d + cma_pkg::SUM_W'(sq_s2[d]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1  <= 1'b0;
			en_s2  <= 1'b0;
			hit_s3 <= 1'b0;
		end else begin
			en_s1  <= issue.en;
			en_s2  <= en_s1;
			hit_s3 <= en_s2 && (cma_pkg::CMP_W'(sum_d) <= cma_pkg::CMP_W'(radius));
		end
	end

	assign hit  = hit_s3;
	assign data = data_s3;

endmodule

// ===== rtl/cma_merge.sv =====
// merge stage: picks the lowest lane that matched in the current row
module cma_merge (
	input  logic [cma_pkg::LANES-1:0]  hit,
	input  cma_pkg::point_t            data [cma_pkg::LANES],
	output logic                       any,
	output logic [cma_pkg::LANE_W-1:0] lane,
	output cma_pkg::point_t            mode
);

	always_comb begin
		any  = |hit;
		lane = '0;
		mode = data[0];
		for (int l = cma_pkg::LANES - 1; l >= 0; l--) begin
			if (hit[l]) begin
				lane = cma_pkg::LANE_W'(l);
				mode = data[l];
			end
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the cluster mode assignment core
`timescale 1ns / 100ps

module tb_top;

	localparam int CYCLE_LIMIT = 300000;
	localparam logic [cma_pkg::RAD_W-1:0] RADIUS_MAX = {cma_pkg::RAD_W{1'b1}};
	localparam logic [cma_pkg::RAD_W-1:0] SPAN_SQ = 34'd12884508675;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	cma_pkg::in_word_t item = '0;
	logic strobe;
	cma_pkg::out_word_t result;
	logic cfg_we = 1'b0;
	logic [cma_pkg::RAD_W-1:0] cfg_wdata = '0;

	cma_pkg::in_word_t point_queue[$];
	cma_pkg::out_word_t assign_queue[$];
	cma_pkg::coord_t modes[cma_pkg::MAX_MODES][cma_pkg::DIMENSIONS];
	int unsigned mode_cnt = 0;
	logic [cma_pkg::RAD_W-1:0] radius = '0;
	bit steady = 1'b0;
	int unsigned mismatches = 0;
	int unsigned cycles = 0;

	cluster_mode_assign_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.strobe(strobe),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	function automatic cma_pkg::out_word_t assign_point(cma_pkg::in_word_t w);
		cma_pkg::coord_t p[cma_pkg::DIMENSIONS];
		cma_pkg::out_word_t r;
		longint unsigned sq_sum;
		longint diff;
		int hit;
		p[0] = w.coord_x;
		p[1] = w.coord_y;
		p[2] = w.coord_z;
		r = '0;
		hit = -1;
		if (w.start_new)
			mode_cnt = 0;
		for (int c = 0; c < mode_cnt; c++) begin
			sq_sum = 0;
			for (int d = 0; d < cma_pkg::DIMENSIONS; d++) begin
				diff = longint'(p[d]) - longint'(modes[c][d]);
				sq_sum += unsigned'(diff * diff);
			end
			if (sq_sum <= {30'b0, radius}) begin
				hit = c;
				break;
			end
		end
		if (hit >= 0) begin
			p = modes[hit];
			r.cluster_index = hit[cma_pkg::IDX_W-1:0];
		end else if (mode_cnt < cma_pkg::MAX_MODES) begin
			modes[mode_cnt] = p;
			r.cluster_index = mode_cnt[cma_pkg::IDX_W-1:0];
			r.created = 1'b1;
			mode_cnt++;
		end else begin
			r.table_full = 1'b1;
		end
		r.mode_x = p[0];
		r.mode_y = p[1];
		r.mode_z = p[2];
		r.clusters_now = mode_cnt[cma_pkg::CNT_W-1:0];
		return r;
	endfunction

	// sender: holds start until the word is taken, then offers the next one
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				assign_queue.push_back(assign_point(item));
			if (!start || !busy) begin
				if (point_queue.size() != 0 && (steady || $urandom_range(99, 0) >= 20)) begin
					start <= 1'b1;
					item <= point_queue.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want !== got) begin
			$display("%0t %s expected %0h got %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// receiver: one word per strobe, compared with the oldest prediction
	always @(posedge clk) begin
		cma_pkg::out_word_t want;
		if (arst_n && strobe) begin
			if (assign_queue.size() == 0) begin
				$display("%0t unexpected word expected none got %0h", $time, result);
				mismatches++;
			end else begin
				want = assign_queue.pop_front();
				check_field("mode_x", want.mode_x, result.mode_x);
				check_field("mode_y", want.mode_y, result.mode_y);
				check_field("mode_z", want.mode_z, result.mode_z);
				check_field("cluster_index", want.cluster_index, result.cluster_index);
				check_field("created", want.created, result.created);
				check_field("table_full", want.table_full, result.table_full);
				check_field("clusters_now", want.clusters_now, result.clusters_now);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic write_radius(input logic [cma_pkg::RAD_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		radius = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		do
			@(negedge clk);
		while (point_queue.size() != 0 || start || assign_queue.size() != 0);
		repeat (24) @(negedge clk);
	endtask

	task automatic add_point(input bit s, input cma_pkg::coord_t x, input cma_pkg::coord_t y,
			input cma_pkg::coord_t z);
		cma_pkg::in_word_t w;
		w.start_new = s;
		w.coord_x = x;
		w.coord_y = y;
		w.coord_z = z;
		point_queue.push_back(w);
	endtask

	function automatic cma_pkg::coord_t jitter(cma_pkg::coord_t c, int spread);
		return c + cma_pkg::coord_t'(int'($urandom_range(2 * spread, 0)) - spread);
	endfunction

	// points scattered around eight random centers; the first one clears the table unless it is drawn at random
	task automatic add_run(input int len);
		cma_pkg::coord_t cx[8], cy[8], cz[8];
		int spread, k;
		for (int i = 0; i < 8; i++) begin
			cx[i] = cma_pkg::coord_t'($urandom);
			cy[i] = cma_pkg::coord_t'($urandom);
			cz[i] = cma_pkg::coord_t'($urandom);
		end
		case ($urandom_range(3, 0))
			0: spread = 1;
			1: spread = 32;
			2: spread = 2048;
			default: spread = 32767;
		endcase
		k = $urandom_range(7, 0);
		for (int n = 0; n < len; n++) begin
			if ($urandom_range(9, 0) == 0)
				add_point($urandom_range(19, 0) == 0, cma_pkg::coord_t'($urandom),
					cma_pkg::coord_t'($urandom), cma_pkg::coord_t'($urandom));
			else begin
				k = $urandom_range(k, 0);
				add_point(n == 0 || $urandom_range(29, 0) == 0, jitter(cx[k], spread),
					jitter(cy[k], spread), jitter(cz[k], spread));
			end
		end
	endtask

	initial begin
		logic [cma_pkg::RAD_W-1:0] r;
		cma_pkg::coord_t fx, fy, fz;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// exact match only, extremes and reuse after clear
		write_radius('0);
		add_point(1'b1, 16'sd0, 16'sd0, 16'sd0);
		add_point(1'b0, 16'sd0, 16'sd0, 16'sd0);
		add_point(1'b0, -16'sd32768, -16'sd32768, -16'sd32768);
		add_point(1'b0, 16'sd32767, 16'sd32767, 16'sd32767);
		add_point(1'b0, 16'sd32767, -16'sd32768, 16'sd0);
		add_point(1'b0, -16'sd32768, 16'sd32767, -16'sd1);
		add_point(1'b0, 16'sd32767, 16'sd32767, 16'sd32767);
		add_point(1'b1, 16'sd32767, 16'sd32767, 16'sd32767);
		add_point(1'b0, -16'sd32768, -16'sd32768, -16'sd32768);
		add_point(1'b0, 16'sd1, 16'sd0, 16'sd0);
		drain();

		write_radius(34'd1);
		add_point(1'b1, 16'sd0, 16'sd0, 16'sd0);
		add_point(1'b0, 16'sd1, 16'sd0, 16'sd0);
		add_point(1'b0, 16'sd1, 16'sd1, 16'sd0);
		add_point(1'b0, 16'sd0, 16'sd0, -16'sd1);
		drain();

		write_radius(RADIUS_MAX);
		add_point(1'b1, -16'sd32768, -16'sd32768, -16'sd32768);
		add_point(1'b0, 16'sd32767, 16'sd32767, 16'sd32767);
		add_point(1'b0, 16'sd0, 16'sd0, 16'sd0);
		drain();

		// radius just below and exactly at the widest possible distance
		write_radius(SPAN_SQ - 1);
		add_point(1'b1, -16'sd32768, -16'sd32768, -16'sd32768);
		add_point(1'b0, 16'sd32767, 16'sd32767, 16'sd32767);
		drain();
		write_radius(SPAN_SQ);
		add_point(1'b1, -16'sd32768, -16'sd32768, -16'sd32768);
		add_point(1'b0, 16'sd32767, 16'sd32767, 16'sd32767);
		drain();

		// fill the table past its end, then hit an old entry while full
		write_radius('0);
		steady = 1'b1;
		fx = cma_pkg::coord_t'($urandom);
		fy = cma_pkg::coord_t'($urandom);
		fz = cma_pkg::coord_t'($urandom);
		add_point(1'b1, fx, fy, fz);
		for (int n = 0; n < 70; n++)
			add_point(1'b0, cma_pkg::coord_t'($urandom), cma_pkg::coord_t'($urandom),
				cma_pkg::coord_t'($urandom));
		add_point(1'b0, fx, fy, fz);
		drain();
		steady = 1'b0;

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 5)
				0: r = '0;
				1: r = cma_pkg::RAD_W'($urandom_range(4096, 1));
				2: r = cma_pkg::RAD_W'($urandom_range(1 << 24, 1 << 16));
				3: r = {2'($urandom_range(3, 0)), 32'($urandom)};
				default: r = RADIUS_MAX;
			endcase
			write_radius(r);
			for (int k = 0; k < 3; k++)
				add_run($urandom_range(20, 6));
			drain();
		end

		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/cma_pkg.sv
rtl/cma_lane.sv
rtl/cma_merge.sv
rtl/cluster_mode_assign_core.sv
tb/tb_top.sv
